@@ sv/gfcc_pkg.sv @@
// shared types and constants for the graph file crc-64 checker
`timescale 1ns / 1ps
`default_nettype none

package gfcc_pkg;

  // crc-64 jones polynomial, msb-first
  localparam logic [63:0] CRC_POLY   = 64'had93_d235_94c9_35a9;
  // file magic, little-endian on the wire
  localparam logic [63:0] FILE_MAGIC = 64'h4353_5200_0000_0001;
  // precision tags
  localparam logic [31:0] TAG_SINGLE = 32'h4650_3332;
  localparam logic [31:0] TAG_DOUBLE = 32'h4650_3634;

  // field lengths in bytes
  localparam logic [3:0] LEN_WORD = 4'd8;
  localparam logic [3:0] LEN_TAG  = 4'd4;

  // status codes
  localparam logic [2:0] ST_BUSY         = 3'd0;
  localparam logic [2:0] ST_VALID        = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC    = 3'd2;
  localparam logic [2:0] ST_TAG_MISMATCH = 3'd3;
  localparam logic [2:0] ST_TRUNC_TAG    = 3'd4;
  localparam logic [2:0] ST_MISSING_CRC  = 3'd5;
  localparam logic [2:0] ST_CRC_MISMATCH = 3'd6;

  typedef enum logic [6:0] {
    PH_MAGIC   = 7'b000_0001,
    PH_TAG     = 7'b000_0010,
    PH_NV      = 7'b000_0100,
    PH_NE      = 7'b000_1000,
    PH_PAYLOAD = 7'b001_0000,
    PH_STORED  = 7'b010_0000,
    PH_DONE    = 7'b100_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        verdict;
    logic [63:0] running_crc;
  } out_req_t;

endpackage

`default_nettype wire

@@ sv/gfcc_crc_step.sv @@
// one byte of the crc-64 jones update, msb-first
`timescale 1ns / 1ps
`default_nettype none

module gfcc_crc_step (
  input  wire logic [63:0] crc_in,
  input  wire logic [7:0]  data_byte,
  output logic      [63:0] crc_out
);

  always_comb begin
    logic [63:0] c;
    c = crc_in ^ {data_byte, 56'd0};
    for (int i = 0; i < 8; i++) begin
      if (c[63]) begin
        c = {c[62:0], 1'b0} ^ gfcc_pkg::CRC_POLY;
      end else begin
        c = {c[62:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

@@ sv/gfcc_parse_core.sv @@
// file parser state, payload counter and crc accumulator, one byte per step
`timescale 1ns / 1ps
`default_nettype none

module gfcc_parse_core #(
  parameter int COUNT_BITS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire gfcc_pkg::in_req_t  req,
  input  wire logic               expect_double,
  output gfcc_pkg::out_req_t      result
);

  localparam int SUM_W = 68;
  localparam logic [SUM_W-1:0] CNT_MAX = (SUM_W'(1) << COUNT_BITS) - SUM_W'(1);

  gfcc_pkg::phase_t        phase_r, phase_nxt;
  logic [3:0]              cnt_r, cnt_nxt;
  logic [63:0]             fs_r, fs_nxt;
  logic [COUNT_BITS-1:0]   vtx_r, vtx_nxt;
  logic [COUNT_BITS-1:0]   pay_r, pay_nxt;
  logic [63:0]             crc_r, crc_nxt;
  logic [2:0]              fin_r, fin_nxt;

  logic [63:0]             crc_step;
  logic [63:0]             fs_ins;
  logic [3:0]              cnt_inc;
  logic [SUM_W-1:0]        vtx_sum;
  logic [SUM_W-1:0]        pay_sum;
  logic [COUNT_BITS-1:0]   pay_dec;
  logic [31:0]             tag_want;

  gfcc_crc_step u_crc (
    .crc_in    (crc_r),
    .data_byte (req.data_byte),
    .crc_out   (crc_step)
  );

  always_comb begin
    fs_ins = fs_r;
    fs_ins[{cnt_r[2:0], 3'b000} +: 8] = fs_r[{cnt_r[2:0], 3'b000} +: 8] | req.data_byte;
    cnt_inc  = cnt_r + 4'd1;
    // (nv + 1) * 8
    vtx_sum  = SUM_W'({fs_ins, 3'b000}) + SUM_W'(8);
    // payload = (nv + 1) * 8 + ne * 8, plus ne * 4 more for 8-byte weights
    pay_sum  = SUM_W'(vtx_r) + SUM_W'({fs_ins, 3'b000}) +
               (expect_double ? SUM_W'({fs_ins, 2'b00}) : SUM_W'(0));
    pay_dec  = pay_r - COUNT_BITS'(1);
    tag_want = expect_double ? gfcc_pkg::TAG_DOUBLE : gfcc_pkg::TAG_SINGLE;
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    fs_nxt    = fs_r;
    vtx_nxt   = vtx_r;
    pay_nxt   = pay_r;
    crc_nxt   = crc_r;
    fin_nxt   = fin_r;
    result.status      = fin_r;
    result.verdict     = 1'b0;
    result.running_crc = crc_r;

    if (phase_r != gfcc_pkg::PH_DONE) begin
      if (phase_r != gfcc_pkg::PH_STORED) begin
        crc_nxt = crc_step;
      end
      if (phase_r != gfcc_pkg::PH_PAYLOAD) begin
        fs_nxt  = fs_ins;
        cnt_nxt = cnt_inc;
      end

      case (phase_r)
        gfcc_pkg::PH_MAGIC: begin
          if (cnt_inc == gfcc_pkg::LEN_WORD) begin
            cnt_nxt = 4'd0;
            fs_nxt  = 64'd0;
            if (fs_ins != gfcc_pkg::FILE_MAGIC) begin
              fin_nxt   = gfcc_pkg::ST_BAD_MAGIC;
              phase_nxt = gfcc_pkg::PH_DONE;
            end else begin
              phase_nxt = gfcc_pkg::PH_TAG;
            end
          end
        end
        gfcc_pkg::PH_TAG: begin
          if (cnt_inc == gfcc_pkg::LEN_TAG) begin
            cnt_nxt = 4'd0;
            fs_nxt  = 64'd0;
            if (fs_ins[31:0] != tag_want) begin
              fin_nxt   = gfcc_pkg::ST_TAG_MISMATCH;
              phase_nxt = gfcc_pkg::PH_DONE;
            end else begin
              phase_nxt = gfcc_pkg::PH_NV;
            end
          end
        end
        gfcc_pkg::PH_NV: begin
          if (cnt_inc == gfcc_pkg::LEN_WORD) begin
            cnt_nxt   = 4'd0;
            fs_nxt    = 64'd0;
            vtx_nxt   = (vtx_sum > CNT_MAX) ? CNT_MAX[COUNT_BITS-1:0]
                                            : vtx_sum[COUNT_BITS-1:0];
            phase_nxt = gfcc_pkg::PH_NE;
          end
        end
        gfcc_pkg::PH_NE: begin
          if (cnt_inc == gfcc_pkg::LEN_WORD) begin
            cnt_nxt   = 4'd0;
            fs_nxt    = 64'd0;
            pay_nxt   = (pay_sum > CNT_MAX) ? CNT_MAX[COUNT_BITS-1:0]
                                            : pay_sum[COUNT_BITS-1:0];
            phase_nxt = (pay_nxt == '0) ? gfcc_pkg::PH_STORED : gfcc_pkg::PH_PAYLOAD;
          end
        end
        gfcc_pkg::PH_PAYLOAD: begin
          pay_nxt = pay_dec;
          if (pay_dec == '0) begin
            cnt_nxt   = 4'd0;
            fs_nxt    = 64'd0;
            phase_nxt = gfcc_pkg::PH_STORED;
          end
        end
        gfcc_pkg::PH_STORED: begin
          if (cnt_inc == gfcc_pkg::LEN_WORD) begin
            cnt_nxt   = 4'd0;
            fs_nxt    = 64'd0;
            fin_nxt   = (fs_ins == crc_r) ? gfcc_pkg::ST_VALID : gfcc_pkg::ST_CRC_MISMATCH;
            phase_nxt = gfcc_pkg::PH_DONE;
          end
        end
        default: begin
        end
      endcase

      if (phase_nxt == gfcc_pkg::PH_DONE) begin
        result.verdict = 1'b1;
      end else if (req.last_byte) begin
        // file ended early
        case (phase_nxt)
          gfcc_pkg::PH_MAGIC: fin_nxt = gfcc_pkg::ST_BAD_MAGIC;
          gfcc_pkg::PH_TAG:   fin_nxt = gfcc_pkg::ST_TRUNC_TAG;
          default:            fin_nxt = gfcc_pkg::ST_MISSING_CRC;
        endcase
        phase_nxt      = gfcc_pkg::PH_DONE;
        cnt_nxt        = 4'd0;
        fs_nxt         = 64'd0;
        result.verdict = 1'b1;
      end

      result.status      = (phase_nxt == gfcc_pkg::PH_DONE) ? fin_nxt : gfcc_pkg::ST_BUSY;
      result.running_crc = crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && req.last_byte)) begin
      phase_r <= gfcc_pkg::PH_MAGIC;
      cnt_r   <= 4'd0;
      fs_r    <= 64'd0;
      vtx_r   <= '0;
      pay_r   <= '0;
      crc_r   <= 64'd0;
      fin_r   <= gfcc_pkg::ST_BUSY;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      fs_r    <= fs_nxt;
      vtx_r   <= vtx_nxt;
      pay_r   <= pay_nxt;
      crc_r   <= crc_nxt;
      fin_r   <= fin_nxt;
    end
  end

  a_verdict_once: assert property (@(posedge clk) disable iff (!rst_n)
    step && result.verdict |-> phase_r != gfcc_pkg::PH_DONE)
    else $error("verdict raised after the file status was already fixed");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step && req.last_byte |=> phase_r == gfcc_pkg::PH_MAGIC && crc_r == 64'd0)
    else $error("parser did not restart after the last byte");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    step && !req.last_byte && phase_r == gfcc_pkg::PH_DONE |=>
      phase_r == gfcc_pkg::PH_DONE && $stable(crc_r) && $stable(fin_r))
    else $error("state moved after the verdict");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == gfcc_pkg::PH_PAYLOAD |-> pay_r != '0)
    else $error("payload phase with nothing left to skip");

endmodule

`default_nettype wire

@@ sv/graph_file_crc64_checker.sv @@
// top level of the graph file crc-64 checker: handshake stages and config register
`timescale 1ns / 1ps
`default_nettype none
// a taken request is parsed as it moves from the input register into the result register behind out_*
// throughput: one byte per cycle unless out_ready holds off; the parser step is combinational logic
// an input register and a result register part the two sides; while a result waits
// for out_ready one more request is taken into the input register, then in_ready drops
// reset (rst_n low, synchronous): parser back to the magic phase, crc cleared, both
// stages empty, expect_double back to 0

module graph_file_crc64_checker #(
  parameter int COUNT_BITS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_wr_data,
  // byte stream in
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire gfcc_pkg::in_req_t  in_data,
  // per-byte results out
  output logic                    out_valid,
  input  wire logic               out_ready,
  output gfcc_pkg::out_req_t      out_data
);

  // precision setting; the user writes it only while no file is in flight, the block does not enforce this
  logic expect_double_r;

  // input stage
  logic               s0_vld_r;
  gfcc_pkg::in_req_t  s0_req_r;

  // result stage
  logic               out_vld_r;
  gfcc_pkg::out_req_t out_req_r;

  logic               advance;
  gfcc_pkg::out_req_t core_result;

  // the held request moves into the result stage when that stage is free or draining
  assign advance  = s0_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s0_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_double_r <= 1'b0;
    end else if (cfg_wr_en) begin
      expect_double_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (in_ready) begin
      s0_vld_r <= in_valid;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_req_r <= in_data;
    end
  end

  gfcc_parse_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .req           (s0_req_r),
    .expect_double (expect_double_r),
    .result        (core_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_req_r <= core_result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_req_r;

endmodule

`default_nettype wire

@@ tb/tb_graph_file_crc64_checker.sv @@
// testbench for the graph file crc-64 checker: streamed files checked against a parser model
`timescale 1ns / 1ps

module tb_graph_file_crc64_checker;

  // long receiver hold-off, long enough to back the block up into its input
  localparam int LONG_STALL = 200;
  // bytes offered per random phase, and number of random phases
  localparam int PHASE_BYTES = 90;
  localparam int NUM_PHASES = 8;

  // kinds of file the random part builds
  typedef enum int {
    FK_GOOD,
    FK_BAD_CRC,
    FK_BAD_TAG,
    FK_BAD_MAGIC,
    FK_TRUNC,
    FK_HUGE,
    FK_NOISE
  } file_kind_t;

  // one row of the directed table; typed rows carry status and verdict as written
  typedef struct packed {
    logic [7:0] b;
    logic       l;
    logic       typed;
    logic [2:0] st;
    logic       vd;
  } dir_row_t;

  localparam int DIR_N = 22;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // one-byte files at both byte extremes: magic cut short
    '{8'h00, 1'b1, 1'b1, gfcc_pkg::ST_BAD_MAGIC, 1'b1},
    '{8'hff, 1'b1, 1'b1, gfcc_pkg::ST_BAD_MAGIC, 1'b1},
    // full magic, little-endian
    '{8'h01, 1'b0, 1'b0, gfcc_pkg::ST_BUSY, 1'b0},
    '{8'h00, 1'b0, 1'b0, gfcc_pkg::ST_BUSY, 1'b0},
    '{8'h00, 1'b0, 1'b0, gfcc_pkg::ST_BUSY, 1'b0},
    '{8'h00, 1'b0, 1'b0, gfcc_pkg::ST_BUSY, 1'b0},
    '{8'h00, 1'b0, 1'b0, gfcc_pkg::ST_BUSY, 1'b0},
    '{8'h52, 1'b0, 1'b0, gfcc_pkg::ST_BUSY, 1'b0},
    '{8'h53, 1'b0, 1'b0, gfcc_pkg::ST_BUSY, 1'b0},
    '{8'h43, 1'b0, 1'b0, gfcc_pkg::ST_BUSY, 1'b0},
    // three bytes of the single tag, then the file ends inside the tag
    '{8'h32, 1'b0, 1'b0, gfcc_pkg::ST_BUSY, 1'b0},
    '{8'h33, 1'b0, 1'b0, gfcc_pkg::ST_BUSY, 1'b0},
    '{8'h50, 1'b1, 1'b1, gfcc_pkg::ST_TRUNC_TAG, 1'b1},
    // magic with a wrong top byte, then one ignored byte carrying the end mark
    '{8'h01, 1'b0, 1'b0, gfcc_pkg::ST_BUSY, 1'b0},
    '{8'h00, 1'b0, 1'b0, gfcc_pkg::ST_BUSY, 1'b0},
    '{8'h00, 1'b0, 1'b0, gfcc_pkg::ST_BUSY, 1'b0},
    '{8'h00, 1'b0, 1'b0, gfcc_pkg::ST_BUSY, 1'b0},
    '{8'h00, 1'b0, 1'b0, gfcc_pkg::ST_BUSY, 1'b0},
    '{8'h52, 1'b0, 1'b0, gfcc_pkg::ST_BUSY, 1'b0},
    '{8'h53, 1'b0, 1'b0, gfcc_pkg::ST_BUSY, 1'b0},
    '{8'h42, 1'b0, 1'b1, gfcc_pkg::ST_BAD_MAGIC, 1'b1},
    '{8'hff, 1'b1, 1'b1, gfcc_pkg::ST_BAD_MAGIC, 1'b0}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic               cfg_wr_data = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  gfcc_pkg::in_req_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  gfcc_pkg::out_req_t out_data;

  graph_file_crc64_checker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // parser model state, our own copy of the block's
  gfcc_pkg::phase_t ph;
  logic [3:0]  fld_cnt;
  logic [63:0] fld_shift;
  logic [63:0] nv_cnt;
  logic [63:0] payload_left;
  logic [63:0] crc_acc;
  logic [2:0]  final_st;
  bit          cfg_double;

  // per-byte results still owed by the block, oldest first
  gfcc_pkg::out_req_t status_q[$];
  // bytes of the file being sent
  logic [7:0]  file_img[$];

  int          errors = 0;
  int          sent_bytes = 0;
  bit          tx_jitter = 1'b1;
  bit          rx_jitter = 1'b1;
  bit          stall_req = 1'b0;
  int          stall_cycles;

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case the handshake locks up
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------- model

  // one msb-first crc-64 byte step, jones polynomial
  function automatic logic [63:0] crc_step(input logic [63:0] c, input logic [7:0] b);
    logic [63:0] r;
    int          i;
    r = c ^ {b, 56'd0};
    for (i = 0; i < 8; i++) r = r[63] ? ((r << 1) ^ gfcc_pkg::CRC_POLY) : (r << 1);
    return r;
  endfunction

  // saturating helpers for the payload size
  function automatic logic [63:0] sat_mul(input logic [63:0] x, input logic [63:0] k);
    if (x > ({64{1'b1}} / k)) return {64{1'b1}};
    return x * k;
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    if (a > ({64{1'b1}} - b)) return {64{1'b1}};
    return a + b;
  endfunction

  function automatic void open_field(input gfcc_pkg::phase_t p);
    ph = p;
    fld_cnt = '0;
    fld_shift = '0;
  endfunction

  function automatic void close_file(input logic [2:0] st);
    final_st = st;
    open_field(gfcc_pkg::PH_DONE);
  endfunction

  function automatic void clear_parser();
    open_field(gfcc_pkg::PH_MAGIC);
    nv_cnt = '0;
    payload_left = '0;
    crc_acc = '0;
    final_st = gfcc_pkg::ST_BUSY;
  endfunction

  // the result one accepted byte should produce, advancing the model
  function automatic gfcc_pkg::out_req_t parse_byte(input logic [7:0] b, input logic last);
    gfcc_pkg::out_req_t r;
    r = '0;
    if (ph != gfcc_pkg::PH_DONE) begin
      // the stored crc itself is left out of the running crc
      if (ph != gfcc_pkg::PH_STORED) crc_acc = crc_step(crc_acc, b);
      if (ph != gfcc_pkg::PH_PAYLOAD) begin
        fld_shift = fld_shift | ({56'd0, b} << {fld_cnt[2:0], 3'b000});
        fld_cnt = fld_cnt + 4'd1;
      end
      case (ph)
        gfcc_pkg::PH_MAGIC: if (fld_cnt == gfcc_pkg::LEN_WORD) begin
          if (fld_shift != gfcc_pkg::FILE_MAGIC) close_file(gfcc_pkg::ST_BAD_MAGIC);
          else open_field(gfcc_pkg::PH_TAG);
        end
        // the tag is judged against the register as it stands on the last tag byte
        gfcc_pkg::PH_TAG: if (fld_cnt == gfcc_pkg::LEN_TAG) begin
          if (fld_shift[31:0] != (cfg_double ? gfcc_pkg::TAG_DOUBLE : gfcc_pkg::TAG_SINGLE))
            close_file(gfcc_pkg::ST_TAG_MISMATCH);
          else open_field(gfcc_pkg::PH_NV);
        end
        gfcc_pkg::PH_NV: if (fld_cnt == gfcc_pkg::LEN_WORD) begin
          nv_cnt = fld_shift;
          open_field(gfcc_pkg::PH_NE);
        end
        // weight size taken from the register on the last byte of the edge count
        gfcc_pkg::PH_NE: if (fld_cnt == gfcc_pkg::LEN_WORD) begin
          payload_left = sat_add(sat_mul(sat_add(nv_cnt, 64'd1), 64'd8),
                                 sat_mul(fld_shift, cfg_double ? 64'd12 : 64'd8));
          open_field(payload_left == 0 ? gfcc_pkg::PH_STORED : gfcc_pkg::PH_PAYLOAD);
        end
        gfcc_pkg::PH_PAYLOAD: begin
          payload_left = payload_left - 64'd1;
          if (payload_left == 0) open_field(gfcc_pkg::PH_STORED);
        end
        gfcc_pkg::PH_STORED: if (fld_cnt == gfcc_pkg::LEN_WORD)
          close_file(fld_shift == crc_acc ? gfcc_pkg::ST_VALID : gfcc_pkg::ST_CRC_MISMATCH);
        default: ;
      endcase
      if (ph == gfcc_pkg::PH_DONE) begin
        r.verdict = 1'b1;
      end else if (last) begin
        // file cut short: what is missing depends on where it stopped
        if (ph == gfcc_pkg::PH_MAGIC) close_file(gfcc_pkg::ST_BAD_MAGIC);
        else if (ph == gfcc_pkg::PH_TAG) close_file(gfcc_pkg::ST_TRUNC_TAG);
        else close_file(gfcc_pkg::ST_MISSING_CRC);
        r.verdict = 1'b1;
      end
      r.status = (ph == gfcc_pkg::PH_DONE) ? final_st : gfcc_pkg::ST_BUSY;
    end else begin
      // verdict already given: bytes ignored, crc holds
      r.status = final_st;
    end
    r.running_crc = crc_acc;
    if (last) clear_parser();
    return r;
  endfunction

  // ------------------------------------------------------------- stimulus

  // idle length: mostly none, sometimes short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic file_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return FK_GOOD;
    if (r < 50) return FK_BAD_CRC;
    if (r < 60) return FK_BAD_TAG;
    if (r < 68) return FK_BAD_MAGIC;
    if (r < 85) return FK_TRUNC;
    if (r < 90) return FK_HUGE;
    return FK_NOISE;
  endfunction

  function automatic void push_word(input logic [63:0] w, input int nbytes);
    int i;
    for (i = 0; i < nbytes; i++) file_img.push_back(w[8*i +: 8]);
  endfunction

  // builds a file image; the tag and the weight size can follow different settings
  function automatic void build_file(input file_kind_t k, input bit tag_dbl, input bit wt_dbl);
    logic [63:0] nv;
    logic [63:0] ne;
    logic [63:0] pay;
    logic [63:0] c;
    logic [31:0] tg;
    int          i;
    int          n;
    file_img.delete();
    if (k == FK_NOISE) begin
      n = $urandom_range(1, 12);
      for (i = 0; i < n; i++) file_img.push_back(8'($urandom));
      return;
    end
    push_word(gfcc_pkg::FILE_MAGIC, 8);
    if (k == FK_BAD_MAGIC) begin
      i = $urandom_range(0, 7);
      file_img[i] = file_img[i] ^ (8'd1 << $urandom_range(0, 7));
    end
    tg = tag_dbl ? gfcc_pkg::TAG_DOUBLE : gfcc_pkg::TAG_SINGLE;
    if (k == FK_BAD_TAG) begin
      // either the other precision or a random word that is surely wrong
      if ($urandom_range(0, 1) == 1) tg = tag_dbl ? gfcc_pkg::TAG_SINGLE : gfcc_pkg::TAG_DOUBLE;
      else tg = tg ^ ($urandom() | 32'd1);
    end
    push_word({32'd0, tg}, 4);
    nv = $urandom_range(0, 3);
    ne = $urandom_range(0, 3);
    if (k == FK_HUGE) begin
      case ($urandom_range(0, 3))
        0: nv = {64{1'b1}};
        1: nv = {$urandom(), $urandom()} | 64'h8000_0000_0000_0000;
        2: ne = {64{1'b1}};
        default: ne = 64'h2000_0000_0000_0000;
      endcase
    end
    push_word(nv, 8);
    push_word(ne, 8);
    if (k == FK_HUGE) begin
      // saturated payload never finishes: the end mark falls inside it or on the last edge count byte
      n = $urandom_range(0, 20);
      for (i = 0; i < n; i++) file_img.push_back(8'($urandom));
      return;
    end
    pay = (nv + 64'd1) * 64'd8 + ne * (wt_dbl ? 64'd12 : 64'd8);
    for (i = 0; i < int'(pay); i++) file_img.push_back(8'($urandom));
    c = '0;
    foreach (file_img[j]) c = crc_step(c, file_img[j]);
    push_word(c, 8);
    if (k == FK_BAD_CRC) begin
      i = file_img.size() - 1 - $urandom_range(0, 7);
      file_img[i] = file_img[i] ^ (8'd1 << $urandom_range(0, 7));
    end
    if (k == FK_TRUNC) begin
      n = $urandom_range(1, file_img.size() - 1);
      while (file_img.size() > n) void'(file_img.pop_back());
    end else if ($urandom_range(0, 3) == 0) begin
      // trailing bytes after the stored crc
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) file_img.push_back(8'($urandom));
    end
  endfunction

  // offers one byte request and waits for it to be taken
  task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
                           input logic [2:0] st, input logic vd);
    int                 gap;
    gfcc_pkg::in_req_t  rq;
    gfcc_pkg::out_req_t want;
    gap = tx_jitter ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rq.data_byte = b;
    rq.last_byte = l;
    in_valid <= 1'b1;
    in_data <= rq;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    want = parse_byte(b, l);
    // typed rows of the directed table stand for themselves
    if (typed) begin
      want.status = st;
      want.verdict = vd;
    end
    status_q.push_back(want);
    sent_bytes++;
  endtask

  // sends part of the file image; the end mark goes on its final byte
  task automatic send_span(input int first, input int stop);
    int i;
    for (i = first; i < stop; i++)
      send_byte(file_img[i], i == file_img.size() - 1, 1'b0, gfcc_pkg::ST_BUSY, 1'b0);
  endtask

  // stop offering and let every owed result come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_expect_double(input bit v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_double = v;
  endtask

  // ------------------------------------------------------------- receiver

  // out_ready with random hold-offs, and the long stall when asked for
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (stall_req) begin
        out_ready <= 1'b0;
        for (stall_cycles = 0; stall_cycles < LONG_STALL; stall_cycles++) @(posedge clk);
        stall_req = 1'b0;
        out_ready <= 1'b1;
      end else if (!rx_jitter) begin
        out_ready <= 1'b1;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (gap - 1) @(posedge clk);
        end
      end
    end
  end

  function automatic void check_field(input string what, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      errors++;
    end
  endfunction

  // every taken result is matched against the oldest owed one
  always @(posedge clk) begin
    gfcc_pkg::out_req_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (status_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        want = status_q.pop_front();
        check_field("status", 64'(want.status), 64'(out_data.status));
        check_field("verdict", 64'(want.verdict), 64'(out_data.verdict));
        check_field("running_crc", want.running_crc, out_data.running_crc);
      end
    end
  end

  // ----------------------------------------------------------------- main

  initial begin
    int p;
    int v;
    int phase_start;
    clear_parser();
    cfg_double = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, register at its reset value (single precision)
    for (int i = 0; i < DIR_N; i++)
      send_byte(DIR_ROWS[i].b, DIR_ROWS[i].l, DIR_ROWS[i].typed, DIR_ROWS[i].st,
                DIR_ROWS[i].vd);
    wait_idle();

    // random files in phases, each phase under one register setting
    for (p = 0; p < NUM_PHASES; p++) begin
      set_expect_double(p < 2 ? p[0] : 1'($urandom_range(0, 1)));
      // phase 1 runs flat out; phase 3 keeps offering through a long receiver stall
      tx_jitter = !(p == 1 || p == 3);
      rx_jitter = (p != 1);
      if (p == 3) stall_req = 1'b1;
      phase_start = sent_bytes;
      while (sent_bytes - phase_start < PHASE_BYTES) begin
        build_file(pick_kind(), cfg_double, cfg_double);
        send_span(0, file_img.size());
      end
      // sender waits here until every owed result is back
      wait_idle();
    end

    // register flipped after the vertex count: the tag follows the old setting,
    // the weight size the new one
    for (v = 0; v < 2; v++) begin
      set_expect_double(v[0]);
      build_file(FK_GOOD, v[0], !v[0]);
      send_span(0, 20);
      wait_idle();
      set_expect_double(!v[0]);
      send_span(20, file_img.size());
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/gfcc_pkg.sv
sv/gfcc_crc_step.sv
sv/gfcc_parse_core.sv
sv/graph_file_crc64_checker.sv
tb/tb_graph_file_crc64_checker.sv
